>>> rtl/core/acc_pkg.sv
package acc_pkg;

	localparam int PC_W   = 13;
	localparam int DATA_W = 32;
	localparam int OP_W   = 4;

	localparam int DATA_WORDS_DEF    = 256;
	localparam int PROGRAM_WORDS_DEF = 4096;

	typedef enum logic [OP_W-1:0] {
		OP_LDA = 4'd0,
		OP_STO = 4'd1,
		OP_ADD = 4'd2,
		OP_SUB = 4'd3,
		OP_JMP = 4'd4,
		OP_JGE = 4'd5,
		OP_JNE = 4'd6,
		OP_STP = 4'd7,
		OP_PUT = 4'd8
	} opcode_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic              is_memory;
		logic              is_indirect;
		logic [DATA_W-1:0] operand;
	} item_t;

endpackage

>>> rtl/core/accumulator_cpu_execute.sv
// Accumulator machine execution core. Feed it the decoded instruction at the
// next_pc of the last result; each request gives exactly one result. After
// reset the data memory is zeroed one word a cycle, so s_axis_tready stays low
// until every word (256 by default) is zeroed; program_length may be written at any
// time the core is idle. Sustained rate is one instruction a cycle while results
// are taken as they appear: the result register is refilled in the cycle it is
// emptied, and a stalled result holds execution and, behind it, the input.
// A request passes the operand address reduction (quotient estimate, then
// remainder) and a synchronous memory read ahead of the execute step.
// A store followed at once by a load of the same word is forwarded.
module accumulator_cpu_execute
	import acc_pkg::*;
#(
	parameter int DATA_WORDS    = DATA_WORDS_DEF,
	parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [PC_W-1:0] cfg_wr_data,    // program_length
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [31:0]     s_axis_tdata,   // operand
	input  logic [5:0]      s_axis_tuser,   // opcode[3:0], is_memory, is_indirect
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [47:0]     m_axis_tdata,   // next_pc[12:0], accumulator[44:13], halted, zero pad
	output logic [1:0]      m_axis_tuser    // put_valid, pointer_unsupported
);

	localparam int AW = $clog2(DATA_WORDS);

	logic              mem_busy, take, item_valid, rd_en, wr_en;
	item_t             item;
	logic [AW-1:0]     item_addr, wr_addr;
	logic [DATA_W-1:0] rd_data, wr_data;

	acc_front #(
		.DATA_WORDS(DATA_WORDS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.mem_busy      (mem_busy),
		.take          (take),
		.item_valid    (item_valid),
		.item          (item),
		.item_addr     (item_addr)
	);

	acc_dmem #(
		.DATA_WORDS(DATA_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (item_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (mem_busy)
	);

	acc_exec #(
		.DATA_WORDS    (DATA_WORDS),
		.PROGRAM_WORDS (PROGRAM_WORDS)
	) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (item_valid),
		.item          (item),
		.item_addr     (item_addr),
		.take          (take),
		.rd_en         (rd_en),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

>>> rtl/core/acc_front.sv
module acc_front
	import acc_pkg::*;
#(
	parameter int DATA_WORDS = DATA_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [31:0]                   s_axis_tdata,  // operand
	input  logic [5:0]                    s_axis_tuser,  // opcode[3:0], is_memory, is_indirect
	input  logic                          mem_busy,
	input  logic                          take,
	output logic                          item_valid,
	output item_t                         item,
	output logic [$clog2(DATA_WORDS)-1:0] item_addr
);

	localparam int AW = $clog2(DATA_WORDS);
	// floor(2^32 / DATA_WORDS); the quotient estimate is at most one short
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DATA_WORDS);

	logic          v_s1, v_s2;
	item_t         item_s1, item_s2;
	logic [31:0]   quot_s1;
	logic [AW-1:0] addr_s2;

	logic          adv1, adv2, in_acc;
	item_t         in_item;
	logic [63:0]   prod_in, prod_qd;
	logic [31:0]   rem, rem_c;

	assign adv2          = !v_s2 || take;
	assign adv1          = !v_s1 || adv2;
	assign s_axis_tready = !mem_busy && adv1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_item.opcode      = s_axis_tuser[3:0];
		in_item.is_memory   = s_axis_tuser[4];
		in_item.is_indirect = s_axis_tuser[5];
		in_item.operand     = s_axis_tdata;
		prod_in = 64'(s_axis_tdata) * 64'(RECIP);
		prod_qd = 64'(quot_s1) * 64'(DATA_WORDS);
		rem     = item_s1.operand - prod_qd[31:0];
		rem_c   = (rem >= 32'(DATA_WORDS)) ? rem - 32'(DATA_WORDS) : rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_acc;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			item_s1 <= in_item;
			quot_s1 <= prod_in[63:32];
		end
		if (adv2) begin
			item_s2 <= item_s1;
			addr_s2 <= rem_c[AW-1:0];
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;
	assign item_addr  = addr_s2;

endmodule

>>> rtl/core/acc_dmem.sv
module acc_dmem
	import acc_pkg::*;
#(
	parameter int DATA_WORDS = DATA_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(DATA_WORDS)-1:0] rd_addr,
	output logic [DATA_W-1:0]             rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(DATA_WORDS)-1:0] wr_addr,
	input  logic [DATA_W-1:0]             wr_data,
	output logic                          busy
);

	localparam int AW = $clog2(DATA_WORDS);

	logic [DATA_W-1:0] mem [DATA_WORDS];
	logic [DATA_W-1:0] rd_data_q;
	logic [AW-1:0]     clr_idx_q;
	logic              busy_q;

	logic              we;
	logic [AW-1:0]     wa;
	logic [DATA_W-1:0] wd;

	// zero sweep after reset, one word a cycle
	always_comb begin
		we = busy_q || wr_en;
		wa = busy_q ? clr_idx_q : wr_addr;
		wd = busy_q ? '0 : wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			if (clr_idx_q == AW'(DATA_WORDS - 1)) busy_q <= 1'b0;
			else clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

>>> rtl/core/acc_exec.sv
module acc_exec
	import acc_pkg::*;
#(
	parameter int DATA_WORDS    = DATA_WORDS_DEF,
	parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [PC_W-1:0]               cfg_wr_data,
	input  logic                          item_valid,
	input  item_t                         item,
	input  logic [$clog2(DATA_WORDS)-1:0] item_addr,
	output logic                          take,
	output logic                          rd_en,
	input  logic [DATA_W-1:0]             rd_data,
	output logic                          wr_en,
	output logic [$clog2(DATA_WORDS)-1:0] wr_addr,
	output logic [DATA_W-1:0]             wr_data,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [47:0]                   m_axis_tdata,  // next_pc, accumulator, halted
	output logic [1:0]                    m_axis_tuser   // put_valid, pointer_unsupported
);

	localparam int AW = $clog2(DATA_WORDS);

	logic              v_s3;
	item_t             item_s3;
	logic [AW-1:0]     addr_s3;
	logic              byp_q;
	logic [DATA_W-1:0] byp_data_q;

	logic [DATA_W-1:0] acc_q;
	logic [PC_W-1:0]   pc_q, plen_q;
	logic              halt_q;

	logic              out_v_q;
	logic [PC_W-1:0]   out_pc_q;
	logic [DATA_W-1:0] out_acc_q;
	logic              out_put_q, out_halt_q, out_ptr_q;

	logic              ex_fire, load, ignore;
	logic [PC_W-1:0]   len;
	logic [PC_W:0]     nxt;
	logic [DATA_W-1:0] acc_n, mem_word, opnd;
	logic              jump, put, ptr, halt_n, sto;

	// result register refills in the cycle it is emptied
	assign ex_fire = v_s3 && (!out_v_q || m_axis_tready);
	assign take    = !v_s3 || ex_fire;
	assign load    = take && item_valid;
	assign rd_en   = load;

	always_comb begin
		len      = (32'(plen_q) < PROGRAM_WORDS) ? plen_q : PC_W'(PROGRAM_WORDS);
		mem_word = byp_q ? byp_data_q : rd_data;
		opnd     = item_s3.is_memory ? mem_word : item_s3.operand;
		ignore   = halt_q || (pc_q >= len);
		acc_n    = acc_q;
		nxt      = {1'b0, pc_q} + 1'b1;
		jump     = 1'b0;
		put      = 1'b0;
		ptr      = 1'b0;
		halt_n   = halt_q;
		sto      = 1'b0;
		unique case (opcode_t'(item_s3.opcode))
			OP_LDA: begin
				if (item_s3.is_indirect) ptr = 1'b1;
				else acc_n = mem_word;
			end
			OP_STO: begin
				if (item_s3.is_indirect) ptr = 1'b1;
				else sto = 1'b1;
			end
			OP_ADD, OP_SUB: begin
				if (item_s3.is_memory && item_s3.is_indirect) ptr = 1'b1;
				else if (opcode_t'(item_s3.opcode) == OP_ADD) acc_n = acc_q + opnd;
				else acc_n = acc_q - opnd;
			end
			OP_JMP: jump = 1'b1;
			OP_JGE: jump = !acc_q[DATA_W-1];
			OP_JNE: jump = (acc_q != '0);
			OP_STP: begin
				halt_n = 1'b1;
				nxt    = {1'b0, pc_q};
			end
			OP_PUT: put = 1'b1;
			default: ;
		endcase
		if (opcode_t'(item_s3.opcode) != OP_STP) begin
			if (jump) begin
				// target is unsigned, so a negative one is past the end
				if (item_s3.operand < 32'(len)) nxt = {1'b0, item_s3.operand[PC_W-1:0]};
				else nxt = (PC_W+1)'(len);
			end else if (nxt > (PC_W+1)'(len)) begin
				nxt = (PC_W+1)'(len);
			end
			if (nxt >= (PC_W+1)'(len)) begin
				nxt    = (PC_W+1)'(len);
				halt_n = 1'b1;
			end
		end
		if (ignore) begin
			acc_n  = acc_q;
			nxt    = {1'b0, pc_q};
			put    = 1'b0;
			ptr    = 1'b0;
			halt_n = 1'b1;
			sto    = 1'b0;
		end
	end

	assign wr_en   = ex_fire && sto;
	assign wr_addr = addr_s3;
	assign wr_data = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3    <= 1'b0;
			byp_q   <= 1'b0;
			acc_q   <= '0;
			pc_q    <= '0;
			halt_q  <= 1'b0;
			plen_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (take) v_s3 <= item_valid;
			// read issued in the same cycle as a store to that word sees stale data
			if (load) byp_q <= wr_en && (wr_addr == item_addr);
			if (ex_fire) begin
				acc_q  <= acc_n;
				pc_q   <= nxt[PC_W-1:0];
				halt_q <= halt_n;
			end
			if (cfg_wr_en) plen_q <= cfg_wr_data;
			if (ex_fire) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s3    <= item;
			addr_s3    <= item_addr;
			byp_data_q <= wr_data;
		end
		if (ex_fire) begin
			out_pc_q   <= nxt[PC_W-1:0];
			out_acc_q  <= acc_n;
			out_put_q  <= put;
			out_halt_q <= halt_n;
			out_ptr_q  <= ptr;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, out_halt_q, out_acc_q, out_pc_q};
	assign m_axis_tuser  = {out_ptr_q, out_put_q};

endmodule

>>> rtl/core/acc_checker.sv
module acc_checker
	import acc_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            s_axis_tvalid,
	input logic            s_axis_tready,
	input logic            m_axis_tvalid,
	input logic            m_axis_tready,
	input logic [47:0]     m_axis_tdata,
	input logic [1:0]      m_axis_tuser
);

	logic              in_acc, out_acc;
	logic [2:0]        cnt_q;
	logic              seen_q;
	logic [PC_W-1:0]   hpc_q;
	logic [DATA_W-1:0] hacc_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// requests in flight, and the state frozen by the first halted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			seen_q <= 1'b0;
			hpc_q  <= '0;
			hacc_q <= '0;
		end else begin
			cnt_q <= cnt_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc && m_axis_tdata[45] && !seen_q) begin
				seen_q <= 1'b1;
				hpc_q  <= m_axis_tdata[12:0];
				hacc_q <= m_axis_tdata[44:13];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> cnt_q != 3'd0)
		else $error("result without a pending request");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("more requests in flight than pipeline stages");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q && m_axis_tvalid |->
			m_axis_tdata[45] && m_axis_tdata[12:0] == hpc_q &&
			m_axis_tdata[44:13] == hacc_q && m_axis_tuser == 2'b00)
		else $error("state moved after halt");

endmodule

bind accumulator_cpu_execute acc_checker u_acc_checker (.*);

>>> tb/accumulator_cpu_execute_test.sv
`timescale 1ns / 1ps

module accumulator_cpu_execute_test;
	import acc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	// opcodes the core treats as no-ops
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd9;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic [DATA_W-1:0] acc;
		logic              put;
		logic              halted;
		logic              ptr;
	} exec_result_t;

	class exec_tracker;
		logic [DATA_W-1:0] acc_q;
		logic [DATA_W-1:0] data_mem [DATA_WORDS_DEF];
		int unsigned       pc_now;
		bit                halted_now;
		int unsigned       prog_len;
		exec_result_t      expected_results[$];
		int                failures;

		function new();
			acc_q = '0;
			foreach (data_mem[i])
				data_mem[i] = '0;
			pc_now = 0;
			halted_now = 0;
			prog_len = 0;
			failures = 0;
		endfunction

		function int unsigned run_limit();
			return (prog_len < PROGRAM_WORDS_DEF) ? prog_len : PROGRAM_WORDS_DEF;
		endfunction

		function void set_length(logic [PC_W-1:0] v);
			prog_len = v;
		endfunction

		function void note_instruction(item_t it);
			exec_result_t      r;
			int unsigned       lim;
			int unsigned       nxt;
			int unsigned       addr;
			logic [DATA_W-1:0] v;
			bit                jump;
			lim = run_limit();
			r = '0;
			if (halted_now || pc_now >= lim) begin
				// ignored request: state frozen, halt reported
				halted_now = 1;
				r.next_pc = pc_now;
				r.acc = acc_q;
				r.halted = 1;
				expected_results.push_back(r);
				return;
			end
			addr = it.operand % DATA_WORDS_DEF;
			nxt = pc_now + 1;
			jump = 0;
			case (it.opcode)
				OP_LDA: begin
					if (it.is_indirect)
						r.ptr = 1;
					else
						acc_q = data_mem[addr];
				end
				OP_STO: begin
					if (it.is_indirect)
						r.ptr = 1;
					else
						data_mem[addr] = acc_q;
				end
				OP_ADD, OP_SUB: begin
					if (it.is_memory && it.is_indirect) begin
						r.ptr = 1;
					end else begin
						v = it.is_memory ? data_mem[addr] : it.operand;
						acc_q = (it.opcode == OP_ADD) ? acc_q + v : acc_q - v;
					end
				end
				OP_JMP: jump = 1;
				OP_JGE: jump = !acc_q[DATA_W-1];
				OP_JNE: jump = (acc_q != '0);
				OP_STP: begin
					halted_now = 1;
					nxt = pc_now;
				end
				OP_PUT: r.put = 1;
				default: ;
			endcase
			if (it.opcode != OP_STP) begin
				if (jump)
					nxt = (it.operand < lim) ? it.operand : lim;
				if (nxt >= lim) begin
					nxt = lim;
					halted_now = 1;
				end
			end
			pc_now = nxt;
			r.next_pc = pc_now;
			r.acc = acc_q;
			r.halted = halted_now;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [DATA_W-1:0] want,
				logic [DATA_W-1:0] got);
			if (got !== want) begin
				failures++;
				if (failures <= 40)
					$display("%0t: %s mismatch, expected %0h, actual %0h",
						$time, name, want, got);
			end
		endfunction

		function void check_result(exec_result_t got);
			exec_result_t want;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= 40)
					$display("%0t: unexpected result, expected none, actual %0h",
						$time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("next_pc", want.next_pc, got.next_pc);
			compare_field("accumulator", want.acc, got.acc);
			compare_field("put_valid", want.put, got.put);
			compare_field("halted", want.halted, got.halted);
			compare_field("pointer_unsupported", want.ptr, got.ptr);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [PC_W-1:0]   cfg_wr_data = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;   // operand
	logic [5:0]        s_axis_tuser = '0;   // opcode[3:0], is_memory, is_indirect
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [47:0]       m_axis_tdata;        // next_pc[12:0], accumulator[44:13], halted, pad
	logic [1:0]        m_axis_tuser;        // put_valid, pointer_unsupported

	exec_tracker tracker = new();

	item_t program_mem [PROGRAM_WORDS_DEF];
	bit    program_set [PROGRAM_WORDS_DEF];

	bit          calm = 0;
	int unsigned sent = 0;
	int          stall_left = 0;
	int unsigned cycles = 0;

	accumulator_cpu_execute dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("accumulator_cpu_execute_test: FAIL");
			$finish;
		end
	end

	// result side back-pressure, quiet in every third stretch of 64 requests
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!calm && (sent / 64) % 3 != 1 && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 14);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		exec_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.next_pc = m_axis_tdata[12:0];
			got.acc = m_axis_tdata[44:13];
			got.halted = m_axis_tdata[45];
			got.put = m_axis_tuser[0];
			got.ptr = m_axis_tuser[1];
			tracker.check_result(got);
		end
	end

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, 7);
			2: return $urandom_range(0, DATA_WORDS_DEF - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_immediate();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// never halts: jumps stay in range and the last slot always jumps back
	function automatic item_t make_instr(int unsigned at, int unsigned lim);
		item_t       it;
		int unsigned r;
		it.is_memory = ($urandom_range(0, 9) < 7);
		it.is_indirect = ($urandom_range(0, 7) == 0);
		r = (at == lim - 1) ? 64 : $urandom_range(0, 99);
		if (r < 18) begin
			it.opcode = OP_LDA;
			it.operand = pick_address();
		end else if (r < 34) begin
			it.opcode = OP_STO;
			it.operand = pick_address();
		end else if (r < 64) begin
			it.opcode = (r < 50) ? OP_ADD : OP_SUB;
			it.operand = it.is_memory ? pick_address() : pick_immediate();
		end else if (r < 82) begin
			it.opcode = (r < 70) ? OP_JMP : (r < 76) ? OP_JGE : OP_JNE;
			it.operand = $urandom_range(0, lim - 1);
		end else if (r < 90) begin
			it.opcode = OP_PUT;
			it.operand = $urandom;
		end else if (r < 96) begin
			it.opcode = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
			it.operand = $urandom;
		end else begin
			it.opcode = OP_ADD;
			it.is_memory = 0;
			it.operand = pick_immediate();
		end
		return it;
	endfunction

	function automatic item_t fetch(int unsigned at, int unsigned lim);
		if (!program_set[at]) begin
			program_mem[at] = make_instr(at, lim);
			program_set[at] = 1;
			// store then load of the same word, back to back
			if (program_mem[at].opcode == OP_STO && !program_mem[at].is_indirect
					&& at + 2 < lim && !program_set[at + 1] && $urandom_range(0, 2) == 0) begin
				program_mem[at + 1] = program_mem[at];
				program_mem[at + 1].opcode = OP_LDA;
				program_mem[at + 1].operand = ($urandom & 32'hFFFF_FF00)
					| (program_mem[at].operand & 32'h0000_00FF);
				program_set[at + 1] = 1;
			end
		end
		return program_mem[at];
	endfunction

	task automatic send_item(item_t it);
		if (!calm && (sent / 64) % 3 != 2 && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it.operand;
		s_axis_tuser <= {it.is_indirect, it.is_memory, it.opcode};
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_instruction(it);
		sent++;
	endtask

	task automatic send_op(logic [OP_W-1:0] op, bit mem, bit ind, logic [31:0] arg);
		item_t it;
		it.opcode = op;
		it.is_memory = mem;
		it.is_indirect = ind;
		it.operand = arg;
		send_item(it);
	endtask

	task automatic write_length(logic [PC_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (tracker.expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		tracker.set_length(v);
		cfg_wr_en <= 1'b0;
	endtask

	// fresh program per phase; ends by jumping to 0 so a new length fits
	task automatic run_phase(int n);
		int unsigned lim;
		lim = tracker.run_limit();
		foreach (program_set[i])
			program_set[i] = 0;
		repeat (n) send_item(fetch(tracker.pc_now, lim));
		send_op(OP_JMP, $urandom_range(0, 1), $urandom_range(0, 1), 32'h0);
	endtask

	initial begin
		int unsigned k;
		int unsigned t;
		int unsigned lim;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		write_length(13'h1FFF);

		send_op(OP_LDA, 0, 0, 32'hFFFF_FFFF);
		send_op(OP_JNE, 1, 0, tracker.pc_now + 5);
		send_op(OP_JGE, 0, 1, tracker.pc_now + 5);
		send_op(OP_ADD, 0, 0, 32'h7FFF_FFFF);
		send_op(OP_ADD, 0, 0, 32'h0000_0001);
		send_op(OP_JGE, 1, 1, tracker.pc_now + 3);
		send_op(OP_JNE, 0, 0, tracker.pc_now + 3);
		send_op(OP_STO, 1, 0, 32'h0000_0000);
		send_op(OP_LDA, 1, 0, 32'h0000_0100);
		send_op(OP_SUB, 0, 0, 32'h0000_0001);
		send_op(OP_SUB, 1, 0, 32'h0000_0000);
		send_op(OP_ADD, 0, 1, 32'h0000_0002);
		send_op(OP_ADD, 1, 1, 32'h0000_0003);
		send_op(OP_SUB, 1, 1, 32'h0000_0004);
		send_op(OP_LDA, 1, 1, 32'h0000_0000);
		send_op(OP_STO, 0, 1, 32'h0000_0005);
		send_op(OP_PUT, 1, 1, 32'hFFFF_FFFF);
		send_op(OP_SPARE_LO, 1, 0, 32'h0000_0000);
		send_op(OP_SPARE_HI, 0, 1, 32'hFFFF_FFFF);
		send_op(OP_STO, 0, 0, 32'h8000_00FF);
		send_op(OP_LDA, 1, 0, 32'h0000_00FF);
		send_op(OP_JMP, 0, 0, PROGRAM_WORDS_DEF - 1);
		send_op(OP_JMP, 1, 1, 32'h0000_0000);

		run_phase(260);
		write_length(PROGRAM_WORDS_DEF);
		run_phase(260);
		write_length($urandom_range(100, PROGRAM_WORDS_DEF - 1));
		run_phase(260);
		write_length(2);
		run_phase(40);
		write_length($urandom_range(3, 40));
		run_phase(120);
		calm = 1;
		write_length($urandom_range(50, 600));
		run_phase(300);

		// one way of ending the run, then requests that must be ignored
		k = $urandom_range(0, 3);
		lim = tracker.run_limit();
		case (k)
			0: send_op(OP_STP, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
			1: begin
				if ($urandom_range(0, 1))
					t = lim + $urandom_range(0, 3);
				else
					t = $urandom | 32'h8000_0000;
				send_op(OP_JMP, $urandom_range(0, 1), $urandom_range(0, 1), t);
			end
			2: begin
				write_length($urandom_range(2, 6));
				while (!tracker.halted_now)
					send_op(OP_ADD, 0, 0, pick_immediate());
			end
			default: begin
				t = $urandom_range(0, 40);
				send_op(OP_JMP, 0, 0, t);
				write_length($urandom_range(0, t));
			end
		endcase
		repeat (12)
			send_op($urandom_range(0, 15), $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom);

		s_axis_tvalid <= 1'b0;
		while (tracker.expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
			$display("accumulator_cpu_execute_test: PASS");
		end else begin
			$display("accumulator_cpu_execute_test: FAIL");
		end
		$finish;
	end

endmodule
